// ===== rtl/phte_pkg.sv =====
// ----------------------------------------------------------------------------
// phte_pkg
// Shared types, constants and the crc32c step function of the hash engine
// ----------------------------------------------------------------------------
package phte_pkg;

  // field widths
  localparam int DATA_W   = 32;
  localparam int VMASK_W  = 12;
  localparam int SMASK_W  = 11;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W = 3;

  // default table depths
  localparam int DEF_VERTEX_DEPTH = 4096;
  localparam int DEF_SLOT_DEPTH   = 2048;

  // hashing constants
  localparam int                ROT_AMOUNT = 15;
  localparam logic [DATA_W-1:0] CRC_POLY   = 32'h82F63B78;
  localparam int                CRC_BITS_PER_CYCLE = 8;
  localparam int                CRC_CYCLES = DATA_W / CRC_BITS_PER_CYCLE;

  // opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_LOAD   = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_ONE    = 3'd0,
    REG_SEED_TWO    = 3'd1,
    REG_SEED_THREE  = 3'd2,
    REG_VERTEX_MASK = 3'd3,
    REG_SLOT_MASK   = 3'd4
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_A,
    S_HASH_B,
    S_VMOD,
    S_VSUM,
    S_SMOD,
    S_FINISH,
    S_LOAD_MOD,
    S_LOAD_WR
  } state_t;

  // crc unit control and status
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] seed;
    logic [DATA_W-1:0] data;
  } crc_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } crc_rsp_t;

  // one cycle worth of reflected crc32c bit steps
  function automatic logic [DATA_W-1:0] crc_step(input logic [DATA_W-1:0] c_in);
    logic [DATA_W-1:0] c;
    logic              lsb;
    c = c_in;
    for (int i = 0; i < CRC_BITS_PER_CYCLE; i++) begin
      lsb = c[0];
      c   = c >> 1;
      if (lsb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/perfect_hash_table_engine.sv =====
// Lookup, insert and delete: two chained crc32c passes, two remainder stages and two
// memory reads lie between acceptance and result. Load reduces the entry index and
// writes the assigned table. One transaction in flight; the next is accepted the
// cycle after the result is registered. Reset: synchronous; afterwards a clearing
// pass zeroes the value table before the first transaction is accepted.
// ----------------------------------------------------------------------------
// perfect_hash_table_engine
// CHM perfect hash table with crc32c vertex hashing and a value store
// ----------------------------------------------------------------------------
module perfect_hash_table_engine import phte_pkg::*; #(
  parameter int VERTEX_DEPTH = DEF_VERTEX_DEPTH,
  parameter int SLOT_DEPTH   = DEF_SLOT_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      opcode,
  input  logic [DATA_W-1:0]    key,
  input  logic [DATA_W-1:0]    new_value,
  input  logic [VMASK_W-1:0]   entry_index,
  input  logic [DATA_W-1:0]    assigned_word,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    result_value,
  output logic [SMASK_W-1:0]   slot_index
);

  localparam int AW_V = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int AW_S = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

  // configuration registers
  logic [DATA_W-1:0]  seed_one;
  logic [DATA_W-1:0]  seed_two;
  logic [DATA_W-1:0]  seed_three;
  logic [VMASK_W-1:0] vertex_mask;
  logic [SMASK_W-1:0] slot_mask;

  // sequencer and captured transaction
  state_t            state;
  state_t            state_next;
  op_t               op_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] new_value_q;
  logic [DATA_W-1:0] word_q;
  logic [AW_V-1:0]   vaddr_q;
  logic [AW_S-1:0]   slot_q;
  logic [AW_S-1:0]   clr_addr;

  // control
  logic              accept;
  logic              is_load;
  logic              out_free;
  logic              clr_last;
  logic              finish_go;
  logic              load_go;
  logic [DATA_W-1:0] key_rot;
  logic [DATA_W-1:0] sum;

  crc_req_t crc_a_req;
  crc_rsp_t crc_a_rsp;
  crc_req_t crc_b_req;
  crc_rsp_t crc_b_rsp;

  logic               vmod_a_valid;
  logic [VMASK_W-1:0] vmod_a_in;
  logic               vmod_a_ok;
  logic [AW_V-1:0]    vmod_a_out;
  logic               vmod_b_valid;
  logic [VMASK_W-1:0] vmod_b_in;
  logic               vmod_b_ok;
  logic [AW_V-1:0]    vmod_b_out;
  logic               smod_valid;
  logic [SMASK_W-1:0] smod_in;
  logic               smod_ok;
  logic [AW_S-1:0]    smod_out;

  logic              vram_we;
  logic              vram_re;
  logic [DATA_W-1:0] vram_rdata_a;
  logic [DATA_W-1:0] vram_rdata_b;
  logic              sram_we;
  logic [AW_S-1:0]   sram_waddr;
  logic [DATA_W-1:0] sram_wdata;
  logic              sram_re;
  logic [DATA_W-1:0] sram_rdata;

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_one    <= '0;
      seed_two    <= '0;
      seed_three  <= '0;
      vertex_mask <= '1;
      slot_mask   <= '1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SEED_ONE:    seed_one    <= cfg_data;
        REG_SEED_TWO:    seed_two    <= cfg_data;
        REG_SEED_THREE:  seed_three  <= cfg_data;
        REG_VERTEX_MASK: vertex_mask <= cfg_data[VMASK_W-1:0];
        REG_SLOT_MASK:   slot_mask   <= cfg_data[SMASK_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake helpers
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_load   = (op_t'(opcode) == OP_LOAD);
  assign out_free  = !out_valid || out_ready;
  assign clr_last  = (clr_addr == AW_S'(SLOT_DEPTH - 1));
  assign finish_go = (state == S_FINISH) && out_free;
  assign load_go   = (state == S_LOAD_WR) && out_free;
  assign key_rot   = (key << ROT_AMOUNT) | (key >> (DATA_W - ROT_AMOUNT));
  assign sum       = vram_rdata_a + vram_rdata_b;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (clr_last) state_next = S_IDLE;
      S_IDLE:     if (accept) state_next = is_load ? S_LOAD_MOD : S_HASH_A;
      S_HASH_A:   if (crc_a_rsp.done && crc_b_rsp.done) state_next = S_HASH_B;
      S_HASH_B:   if (crc_b_rsp.done) state_next = S_VMOD;
      S_VMOD:     if (vmod_a_ok && vmod_b_ok) state_next = S_VSUM;
      S_VSUM:     state_next = S_SMOD;
      S_SMOD:     if (smod_ok) state_next = S_FINISH;
      S_FINISH:   if (out_free) state_next = S_IDLE;
      S_LOAD_MOD: if (vmod_a_ok) state_next = S_LOAD_WR;
      S_LOAD_WR:  if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    // first pass: h1 on unit a, rotated key on unit b; second pass on unit b
    crc_a_req.start = accept && !is_load;
    crc_a_req.seed  = seed_one;
    crc_a_req.data  = key;
    crc_b_req.start = (accept && !is_load) || ((state == S_HASH_A) && crc_b_rsp.done);
    crc_b_req.seed  = (state == S_HASH_A) ? crc_b_rsp.result : seed_two;
    crc_b_req.data  = (state == S_HASH_A) ? (seed_three ^ key_q) : key_rot;

    // vertex remainders; unit a also reduces the load index
    vmod_a_valid = (accept && is_load) || ((state == S_HASH_B) && crc_b_rsp.done);
    vmod_a_in    = (state == S_IDLE) ? entry_index
                                     : (crc_a_rsp.result[VMASK_W-1:0] & vertex_mask);
    vmod_b_valid = (state == S_HASH_B) && crc_b_rsp.done;
    vmod_b_in    = crc_b_rsp.result[VMASK_W-1:0] & vertex_mask;

    // assigned table access
    vram_re = (state == S_VMOD) && vmod_a_ok && vmod_b_ok;
    vram_we = load_go;

    // slot reduction and value table access
    smod_valid = (state == S_VSUM);
    smod_in    = sum[SMASK_W-1:0] & slot_mask;
    sram_re    = (state == S_SMOD) && smod_ok;
    if (state == S_CLEAR) begin
      sram_we    = 1'b1;
      sram_waddr = clr_addr;
      sram_wdata = '0;
    end else begin
      sram_we    = finish_go && ((op_q == OP_INSERT) || (op_q == OP_DELETE));
      sram_waddr = slot_q;
      sram_wdata = (op_q == OP_INSERT) ? new_value_q : '0;
    end
  end

  // state register and clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW_S'(1);
      end
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q        <= op_t'(opcode);
      key_q       <= key;
      new_value_q <= new_value;
      word_q      <= assigned_word;
    end
    if ((state == S_LOAD_MOD) && vmod_a_ok) begin
      vaddr_q <= vmod_a_out;
    end
    if (sram_re) begin
      slot_q <= smod_out;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go || load_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      result_value <= sram_rdata;
      slot_index   <= SMASK_W'(slot_q);
    end else if (load_go) begin
      result_value <= '0;
      slot_index   <= '0;
    end
  end

  // hashing units
  phte_crc_unit u_crc_a (
    .clk (clk),
    .rst (rst),
    .req (crc_a_req),
    .rsp (crc_a_rsp)
  );

  phte_crc_unit u_crc_b (
    .clk (clk),
    .rst (rst),
    .req (crc_b_req),
    .rsp (crc_b_rsp)
  );

  // remainder units
  phte_mod_unit #(
    .DIVISOR (VERTEX_DEPTH),
    .IN_W    (VMASK_W),
    .OUT_W   (AW_V)
  ) u_vmod_a (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vmod_a_valid),
    .in_x      (vmod_a_in),
    .out_valid (vmod_a_ok),
    .out_rem   (vmod_a_out)
  );

  phte_mod_unit #(
    .DIVISOR (VERTEX_DEPTH),
    .IN_W    (VMASK_W),
    .OUT_W   (AW_V)
  ) u_vmod_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vmod_b_valid),
    .in_x      (vmod_b_in),
    .out_valid (vmod_b_ok),
    .out_rem   (vmod_b_out)
  );

  phte_mod_unit #(
    .DIVISOR (SLOT_DEPTH),
    .IN_W    (SMASK_W),
    .OUT_W   (AW_S)
  ) u_smod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (smod_valid),
    .in_x      (smod_in),
    .out_valid (smod_ok),
    .out_rem   (smod_out)
  );

  // memories
  phte_assigned_ram #(
    .DEPTH (VERTEX_DEPTH),
    .AW    (AW_V)
  ) u_assigned_ram (
    .clk     (clk),
    .we      (vram_we),
    .waddr   (vaddr_q),
    .wdata   (word_q),
    .re      (vram_re),
    .raddr_a (vmod_a_out),
    .raddr_b (vmod_b_out),
    .rdata_a (vram_rdata_a),
    .rdata_b (vram_rdata_b)
  );

  phte_value_ram #(
    .DEPTH (SLOT_DEPTH),
    .AW    (AW_S)
  ) u_value_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (sram_wdata),
    .re    (sram_re),
    .raddr (smod_out),
    .rdata (sram_rdata)
  );

  // a result appears only from the finishing states
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH || $past(state) == S_LOAD_WR))
    else $error("result registered outside a finishing state");

  // one transaction at a time
  a_single_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

  // the computed slot lies inside the value table
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> (slot_q <= AW_S'(SLOT_DEPTH - 1)))
    else $error("slot beyond value table depth");

  // no transaction is taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !$past(in_ready))
    else $error("transaction accepted during clearing pass");

endmodule

// ===== rtl/phte_crc_unit.sv =====
// ----------------------------------------------------------------------------
// phte_crc_unit
// Iterative crc32c over one 32-bit word, eight bits per cycle
// ----------------------------------------------------------------------------
module phte_crc_unit import phte_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  crc_req_t req,
  output crc_rsp_t rsp
);

  localparam int CNT_W = $clog2(CRC_CYCLES);

  logic [DATA_W-1:0] crc;
  logic [CNT_W-1:0]  cnt;
  logic              active;
  logic              done;

  // control: start loads, then step cycles run until the counter reaches its last step
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == CNT_W'(CRC_CYCLES - 1));
      if (req.start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(CRC_CYCLES - 1)) begin
          active <= 1'b0;
        end
      end
    end
  end

  // datapath: crc register
  always_ff @(posedge clk) begin
    if (req.start) begin
      crc <= req.seed ^ req.data;
    end else if (active) begin
      crc <= crc_step(crc);
    end
  end

  assign rsp.done   = done;
  assign rsp.result = crc;

endmodule

// ===== rtl/phte_mod_unit.sv =====
// ----------------------------------------------------------------------------
// phte_mod_unit
// Two-stage remainder by a constant divisor via reciprocal multiply
// ----------------------------------------------------------------------------
module phte_mod_unit import phte_pkg::*; #(
  parameter int DIVISOR = DEF_VERTEX_DEPTH,
  parameter int IN_W    = VMASK_W,
  parameter int OUT_W   = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [IN_W-1:0]  in_x,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_rem
);

  // estimate of the quotient is low by at most one for inputs below 2**IN_W
  localparam int              SH      = 2 * IN_W;
  localparam int              RW      = SH + 1;
  localparam int              PW      = IN_W + RW;
  localparam longint unsigned RECIP_L = (64'd1 << SH) / DIVISOR;
  localparam logic [RW-1:0]   RECIP   = RW'(RECIP_L);
  localparam logic [IN_W-1:0] DIV_LOW = IN_W'(DIVISOR);
  localparam int DW = $clog2(DIVISOR + 1);
  localparam int CW = ((IN_W > DW) ? IN_W : DW) + 1;
  localparam logic [CW-1:0]   DIV_C   = CW'(DIVISOR);

  logic [IN_W-1:0] x1;
  logic [PW-1:0]   prod1;
  logic            v1;
  logic [IN_W-1:0] q;
  logic [IN_W-1:0] qd;
  logic [IN_W-1:0] r;
  logic [CW-1:0]   r_ext;
  logic [CW-1:0]   r_fix;

  // stage one: reciprocal multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x1    <= in_x;
    prod1 <= PW'(in_x) * PW'(RECIP);
  end

  // stage two: back-multiply, subtract, one correction
  always_comb begin
    q     = prod1[SH +: IN_W];
    qd    = q * DIV_LOW;
    r     = x1 - qd;
    r_ext = CW'(r);
    r_fix = (r_ext >= DIV_C) ? (r_ext - DIV_C) : r_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    out_rem <= OUT_W'(r_fix);
  end

endmodule

// ===== rtl/phte_assigned_ram.sv =====
// ----------------------------------------------------------------------------
// phte_assigned_ram
// Assigned table: one write port, two registered read ports
// ----------------------------------------------------------------------------
module phte_assigned_ram import phte_pkg::*; #(
  parameter int DEPTH = DEF_VERTEX_DEPTH,
  parameter int AW    = $clog2(DEF_VERTEX_DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/phte_value_ram.sv =====
// ----------------------------------------------------------------------------
// phte_value_ram
// Value table: one write port, one registered read port
// ----------------------------------------------------------------------------
module phte_value_ram import phte_pkg::*; #(
  parameter int DEPTH = DEF_SLOT_DEPTH,
  parameter int AW    = $clog2(DEF_SLOT_DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/sv/perfect_hash_table_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perfect_hash_table_engine_tb
// Drives lookup, insert, delete and load transactions through the hash engine
// under several seed and mask settings, with random idling on both channels.
// Each result is checked against a bit-accurate scoreboard of the crc32c
// vertex hashing, the assigned table and the value store.
// ----------------------------------------------------------------------------
module perfect_hash_table_engine_tb;
  import phte_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int DRAIN_CYCLES    = 24;

  // scoreboard holding the predicted engine state and the expected results
  class hash_scoreboard;
    typedef struct {
      logic [DATA_W-1:0]  value;
      logic [SMASK_W-1:0] slot;
    } slot_result_t;

    logic [DATA_W-1:0]  seed_a;
    logic [DATA_W-1:0]  seed_b;
    logic [DATA_W-1:0]  seed_c;
    logic [VMASK_W-1:0] vmask;
    logic [SMASK_W-1:0] smask;
    logic [DATA_W-1:0]  vertex_words [DEF_VERTEX_DEPTH];
    bit                 vertex_loaded [DEF_VERTEX_DEPTH];
    logic [DATA_W-1:0]  slot_values [DEF_SLOT_DEPTH];
    slot_result_t       awaited [$];
    int                 errors;

    function new();
      seed_a = '0;
      seed_b = '0;
      seed_c = '0;
      vmask  = '1;
      smask  = '1;
      errors = 0;
      foreach (vertex_words[i]) begin
        vertex_words[i]  = '0;
        vertex_loaded[i] = 1'b0;
      end
      foreach (slot_values[i]) begin
        slot_values[i] = '0;
      end
    endfunction

    function void set_register(cfg_reg_t r, logic [DATA_W-1:0] d);
      case (r)
        REG_SEED_ONE:    seed_a = d;
        REG_SEED_TWO:    seed_b = d;
        REG_SEED_THREE:  seed_c = d;
        REG_VERTEX_MASK: vmask  = d[VMASK_W-1:0];
        REG_SLOT_MASK:   smask  = d[SMASK_W-1:0];
        default: ;
      endcase
    endfunction

    // reflected crc32c over one 32-bit word, no inversion
    function logic [DATA_W-1:0] crc_fold(logic [DATA_W-1:0] c0, logic [DATA_W-1:0] d);
      logic [DATA_W-1:0] c;
      c = c0 ^ d;
      for (int i = 0; i < DATA_W; i++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    // the two assigned table addresses a key hashes to
    function void vertex_pair(input logic [DATA_W-1:0] k,
                              output logic [VMASK_W-1:0] a1,
                              output logic [VMASK_W-1:0] a2);
      logic [DATA_W-1:0] rot;
      logic [DATA_W-1:0] h1;
      logic [DATA_W-1:0] h2;
      rot = (k << ROT_AMOUNT) | (k >> (DATA_W - ROT_AMOUNT));
      h1  = crc_fold(seed_a, k);
      h2  = crc_fold(crc_fold(seed_b, rot), seed_c ^ k);
      a1  = h1[VMASK_W-1:0] & vmask;
      a2  = h2[VMASK_W-1:0] & vmask;
    endfunction

    // update the predicted state for an accepted request
    function void note_request(op_t op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] nv,
                               logic [VMASK_W-1:0] ei, logic [DATA_W-1:0] aw);
      logic [VMASK_W-1:0] a1;
      logic [VMASK_W-1:0] a2;
      logic [DATA_W-1:0]  sum;
      slot_result_t       r;
      if (op == OP_LOAD) begin
        vertex_words[ei]  = aw;
        vertex_loaded[ei] = 1'b1;
        r.value = '0;
        r.slot  = '0;
      end else begin
        vertex_pair(k, a1, a2);
        sum     = vertex_words[a1] + vertex_words[a2];
        r.slot  = sum[SMASK_W-1:0] & smask;
        r.value = slot_values[r.slot];
        if (op == OP_INSERT) begin
          slot_values[r.slot] = nv;
        end else if (op == OP_DELETE) begin
          slot_values[r.slot] = '0;
        end
      end
      awaited.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [DATA_W-1:0] value, logic [SMASK_W-1:0] slot);
      slot_result_t r;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result value %h slot %0d", value, slot));
      end else begin
        r = awaited.pop_front();
        if (value !== r.value) begin
          report($sformatf("result_value %h, predicted %h", value, r.value));
        end
        if (slot !== r.slot) begin
          report($sformatf("slot_index %0d, predicted %0d", slot, r.slot));
        end
      end
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_write     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [DATA_W-1:0]    cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      opcode        = '0;
  logic [DATA_W-1:0]    key           = '0;
  logic [DATA_W-1:0]    new_value     = '0;
  logic [VMASK_W-1:0]   entry_index   = '0;
  logic [DATA_W-1:0]    assigned_word = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [DATA_W-1:0]    result_value;
  logic [SMASK_W-1:0]   slot_index;

  hash_scoreboard board;
  bit             calm = 1'b0;
  int             cycle_count = 0;

  perfect_hash_table_engine dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .key           (key),
    .new_value     (new_value),
    .entry_index   (entry_index),
    .assigned_word (assigned_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_value  (result_value),
    .slot_index    (slot_index)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 8);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result(result_value, slot_index);
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("perfect_hash_table_engine_tb: errors");
      $finish;
    end
  end

  // present one request and hold it until the engine accepts it
  task automatic send_item(op_t op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] nv,
                           logic [VMASK_W-1:0] ei, logic [DATA_W-1:0] aw);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(24, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    key           <= k;
    new_value     <= nv;
    entry_index   <= ei;
    assigned_word <= aw;
    do @(posedge clk); while (!in_ready);
    board.note_request(op, k, nv, ei, aw);
  endtask

  // key operation, loading any vertex entry it would read that is still unwritten
  task automatic send_key(op_t op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] nv);
    logic [VMASK_W-1:0] a1;
    logic [VMASK_W-1:0] a2;
    board.vertex_pair(k, a1, a2);
    if (!board.vertex_loaded[a1]) begin
      send_item(OP_LOAD, $urandom(), $urandom(), a1, $urandom());
    end
    if (!board.vertex_loaded[a2]) begin
      send_item(OP_LOAD, $urandom(), $urandom(), a2, $urandom());
    end
    send_item(op, k, nv, VMASK_W'($urandom()), $urandom());
  endtask

  // drop the request and wait until every result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write every register; unused upper data bits carry noise
  task automatic configure(logic [DATA_W-1:0] s1, logic [DATA_W-1:0] s2,
                           logic [DATA_W-1:0] s3, logic [VMASK_W-1:0] vm,
                           logic [SMASK_W-1:0] sm);
    logic [DATA_W-1:0] word [5];
    cfg_reg_t          r;
    word[0] = s1;
    word[1] = s2;
    word[2] = s3;
    word[3] = ($urandom() & 32'hFFFF_F000) | DATA_W'(vm);
    word[4] = ($urandom() & 32'hFFFF_F800) | DATA_W'(sm);
    for (int i = 0; i < 5; i++) begin
      r = cfg_reg_t'(i);
      cfg_write <= 1'b1;
      cfg_index <= r;
      cfg_data  <= word[i];
      @(posedge clk);
      board.set_register(r, word[i]);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [VMASK_W-1:0] a1;
    logic [VMASK_W-1:0] a2;
    logic [VMASK_W-1:0] ei;
    logic [DATA_W-1:0]  k;
    logic [DATA_W-1:0]  recent [$];
    op_t                op;
    board = new();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, wrapped vertex sum, every operation
    send_item(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd0, 32'h0000_0000);
    send_item(OP_LOAD, 32'h0000_0000, 32'h0000_0000, 12'hFFF, 32'hFFFF_FFFF);
    board.vertex_pair(32'hFFFF_FFFF, a1, a2);
    send_item(OP_LOAD, $urandom(), $urandom(), a1, 32'hFFFF_FFFF);
    send_item(OP_LOAD, $urandom(), $urandom(), a2, 32'hFFFF_FFFF);
    send_key(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_key(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_key(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_key(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_key(OP_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
    send_key(OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_key(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
    send_key(OP_DELETE, 32'h8000_0001, 32'h0000_0000);
    send_key(OP_INSERT, 32'h0000_7FFF, 32'h0000_0001);
    send_key(OP_LOOKUP, 32'h0000_7FFF, 32'hFFFF_FFFF);

    // random phases over a range of seed and mask settings
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      recent.delete();
      case (p)
        0: configure($urandom(), $urandom(), $urandom(), 12'hFFF, 11'h7FF);
        1: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'h000, 11'h000);
        2: configure($urandom(), $urandom(), $urandom(), 12'h00F, 11'h007);
        3: configure($urandom(), $urandom(), $urandom(), 12'h03F, 11'h01F);
        4: configure($urandom(), $urandom(), $urandom(),
                     VMASK_W'($urandom()), SMASK_W'($urandom()));
        default: configure($urandom(), $urandom(), $urandom(), 12'h0FF, 11'h7FF);
      endcase
      // one phase with no idling on either side
      calm = (p == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 12) begin
          ei = $urandom_range(1) ? (VMASK_W'($urandom()) & board.vmask)
                                 : VMASK_W'($urandom_range(DEF_VERTEX_DEPTH - 1));
          send_item(OP_LOAD, $urandom(), $urandom(), ei, $urandom());
        end else begin
          // reuse recent keys so that slots are hit again
          if (recent.size() != 0 && $urandom_range(1)) begin
            k = recent[$urandom_range(recent.size() - 1)];
          end else begin
            k = $urandom();
            recent.push_back(k);
            if (recent.size() > 12) begin
              void'(recent.pop_front());
            end
          end
          case ($urandom_range(9))
            0, 1, 2, 3: op = OP_LOOKUP;
            4, 5, 6:    op = OP_INSERT;
            default:    op = OP_DELETE;
          endcase
          send_key(op, k, $urandom());
        end
      end
    end

    wait_drained();
    if (board.errors == 0) begin
      $display("perfect_hash_table_engine_tb: clean");
    end else begin
      $display("perfect_hash_table_engine_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/phte_pkg.sv
rtl/phte_crc_unit.sv
rtl/phte_mod_unit.sv
rtl/phte_assigned_ram.sv
rtl/phte_value_ram.sv
rtl/perfect_hash_table_engine.sv
tb/sv/perfect_hash_table_engine_tb.sv
